// File: rtl/core/idci_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt distributor package
// Shared types, constants and register offsets for the distributor block.
// ----------------------------------------------------------------------------
package idci_pkg;

   localparam int NumLines   = 64;
   localparam int LineBits   = 6;
   localparam int EnWords    = (NumLines + 31) / 32;
   localparam int ByteWords  = (NumLines + 3) / 4;
   localparam int CfgWords   = (NumLines + 15) / 16;

   localparam logic [9:0] NoLine = 10'h3FF;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LINE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_SCAN = 2'd1,
      BK_DONE = 2'd2
   } bk_state_type;

   // A classified item as it travels from the front to the back.
   typedef struct packed {
      cmd_type     cmd;
      logic        cpu_side;
      logic [11:0] byte_offset;
      logic [31:0] write_data;
      logic [5:0]  line_number;
      logic        line_level;
      logic        bad;
   } item_type;

   localparam logic [11:0] OffCtlr   = 12'h000;
   localparam logic [11:0] OffTyper  = 12'h004;
   localparam logic [11:0] OffIar    = 12'h00C;
   localparam logic [11:0] OffEoir   = 12'h010;
   localparam logic [11:0] OffSetEn  = 12'h100;
   localparam logic [11:0] OffClrEn  = 12'h180;
   localparam logic [11:0] OffSetPnd = 12'h200;
   localparam logic [11:0] OffClrPnd = 12'h280;
   localparam logic [11:0] OffPrio   = 12'h400;
   localparam logic [11:0] OffTgt    = 12'h800;
   localparam logic [11:0] OffCfg    = 12'hC00;
   localparam logic [11:0] OffSgir   = 12'hF00;

endpackage

// File: rtl/core/idci_front.sv
// ----------------------------------------------------------------------------
// Interrupt distributor front end
// Accepts items, flags bad offsets and queues them for the back end.
// ----------------------------------------------------------------------------
module idci_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_command,
   input  logic                 req_cpu_side,
   input  logic [11:0]          req_byte_offset,
   input  logic [31:0]          req_write_data,
   input  logic [5:0]           req_line_number,
   input  logic                 req_line_level,
   output logic                 q_valid,
   output idci_pkg::item_type   q_item,
   input  logic                 q_pop
);

   idci_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               bad;
   logic               push;
   logic [11:0]        off;

   always_comb begin
      off = req_byte_offset;
      bad = 1'b0;
      if ((req_command == idci_pkg::CMD_READ) || (req_command == idci_pkg::CMD_WRITE)) begin
         if (off[1:0] != 2'b00) begin
            bad = 1'b1;
         end else if (req_cpu_side) begin
            bad = !((off == idci_pkg::OffCtlr) || (off == idci_pkg::OffTyper) ||
                    (off == idci_pkg::OffIar) || (off == idci_pkg::OffEoir));
         end else begin
            bad = !((off == idci_pkg::OffCtlr) || (off == idci_pkg::OffTyper) ||
               (off >= idci_pkg::OffSetEn  && off < idci_pkg::OffSetEn  + 12'(4*idci_pkg::EnWords)) ||
               (off >= idci_pkg::OffClrEn  && off < idci_pkg::OffClrEn  + 12'(4*idci_pkg::EnWords)) ||
               (off >= idci_pkg::OffSetPnd && off < idci_pkg::OffSetPnd + 12'(4*idci_pkg::EnWords)) ||
               (off >= idci_pkg::OffClrPnd && off < idci_pkg::OffClrPnd + 12'(4*idci_pkg::EnWords)) ||
               (off >= idci_pkg::OffPrio   && off < idci_pkg::OffPrio   + 12'(4*idci_pkg::ByteWords)) ||
               (off >= idci_pkg::OffTgt    && off < idci_pkg::OffTgt    + 12'(4*idci_pkg::ByteWords)) ||
               (off >= idci_pkg::OffCfg    && off < idci_pkg::OffCfg    + 12'(4*idci_pkg::CfgWords)) ||
               (off == idci_pkg::OffSgir));
         end
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{cmd: idci_pkg::cmd_type'(req_command),
            cpu_side: req_cpu_side, byte_offset: req_byte_offset,
            write_data: req_write_data, line_number: req_line_number,
            line_level: req_line_level, bad: bad};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/idci_back.sv
// ----------------------------------------------------------------------------
// Interrupt distributor back end
// Executes register accesses and line events, scans lines one per cycle.
// ----------------------------------------------------------------------------
module idci_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 groups_minus_one,
   input  logic                 q_valid,
   input  idci_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_read_data,
   output logic                 rsp_irq_request,
   output logic                 rsp_bad_offset
);

   localparam int N = idci_pkg::NumLines;
   localparam int L = idci_pkg::LineBits;
   localparam int B = idci_pkg::ByteWords;

   logic [N-1:0] en_ff, pnd_ff, act_ff, edge_ff, high_ff;
   // Priority and target bytes are kept four lines to a word.
   logic [31:0]  prio_ff [B];
   logic [31:0]  tgt_ff  [B];
   logic         dist_on_ff, cpu_on_ff;
   logic [7:0]   pmr_ff;

   idci_pkg::bk_state_type state_ff, state_in;
   idci_pkg::item_type     cur_ff;
   logic [L:0]   idx_ff, idx_in;
   logic [9:0]   best_ff, best_in;
   logic [8:0]   best_prio_ff, best_prio_in;
   logic         ovalid_ff;
   logic [31:0]  odata_ff;
   logic         oirq_ff, obad_ff;

   logic         take, scan_last, out_free, cand;
   logic [N-1:0] pend_now;
   logic [L-1:0] sidx;
   logic [7:0]   sprio;
   logic [11:0]  off;
   logic [11:0]  rel;
   logic         is_iar;

   assign pend_now = pnd_ff | (~edge_ff & high_ff);
   assign sidx     = idx_ff[L-1:0];
   assign sprio    = prio_ff[sidx[L-1:2]][8*sidx[1:0] +: 8];
   assign off      = cur_ff.byte_offset;
   assign out_free = !ovalid_ff || !rsp_stall;
   assign take     = (state_ff == idci_pkg::BK_IDLE) && q_valid;
   assign q_pop    = take;
   assign scan_last = (idx_ff == (L+1)'(N - 1));
   assign is_iar   = (cur_ff.cmd == idci_pkg::CMD_READ) && !cur_ff.bad &&
                     cur_ff.cpu_side && (off == idci_pkg::OffIar);
   assign cand = dist_on_ff && cpu_on_ff && en_ff[sidx] && pend_now[sidx] &&
                 !act_ff[sidx] && (sprio < pmr_ff) &&
                 ({1'b0, sprio} < best_prio_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idci_pkg::BK_IDLE: if (take) state_in = idci_pkg::BK_SCAN;
         idci_pkg::BK_SCAN: if (scan_last) state_in = idci_pkg::BK_DONE;
         idci_pkg::BK_DONE: if (out_free) state_in = idci_pkg::BK_IDLE;
         default:           state_in = idci_pkg::BK_IDLE;
      endcase
   end

   // The first scan pass serves an acknowledge read; the done state applies
   // the item, and a second scan is not needed because irq is evaluated
   // after the update combinationally in the final pass below.
   always_comb begin
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      case (state_ff)
         idci_pkg::BK_IDLE: begin
            idx_in       = '0;
            best_in      = idci_pkg::NoLine;
            best_prio_in = 9'h100;
         end
         idci_pkg::BK_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (cand) begin
               best_in      = 10'(sidx);
               best_prio_in = {1'b0, sprio};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idci_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      if (take) cur_ff <= q_item;
   end

   // Apply stage: next values of all stores for the current item.
   logic [N-1:0] en_in, pnd_in, act_in, edge_in, high_in;
   logic [31:0]  prio_in [B];
   logic [31:0]  tgt_in  [B];
   logic         dist_on_in, cpu_on_in;
   logic [7:0]   pmr_in;
   logic [31:0]  rd_in;
   logic         wr, rdc;
   logic [N-1:0] pend_after, deliver;
   logic         irq_in;
   int           w;

   assign wr  = (cur_ff.cmd == idci_pkg::CMD_WRITE) && !cur_ff.bad;
   assign rdc = (cur_ff.cmd == idci_pkg::CMD_READ) && !cur_ff.bad;

   always_comb begin
      en_in = en_ff; pnd_in = pnd_ff; act_in = act_ff; edge_in = edge_ff;
      high_in = high_ff; dist_on_in = dist_on_ff; cpu_on_in = cpu_on_ff;
      pmr_in = pmr_ff; rd_in = '0; rel = '0; w = 0;
      for (int i = 0; i < B; i++) begin
         prio_in[i] = prio_ff[i];
         tgt_in[i]  = tgt_ff[i];
      end
      if (cur_ff.cmd == idci_pkg::CMD_LINE) begin
         if (edge_ff[cur_ff.line_number] && cur_ff.line_level &&
             !high_ff[cur_ff.line_number])
            pnd_in[cur_ff.line_number] = 1'b1;
         high_in[cur_ff.line_number] = cur_ff.line_level;
      end else if ((wr || rdc) && cur_ff.cpu_side) begin
         if (off == idci_pkg::OffCtlr) begin
            if (wr) cpu_on_in = cur_ff.write_data[0];
            else rd_in = {31'd0, cpu_on_ff};
         end else if (off == idci_pkg::OffTyper) begin
            if (wr) pmr_in = cur_ff.write_data[7:0];
            else rd_in = {24'd0, pmr_ff};
         end else if (off == idci_pkg::OffIar) begin
            if (rdc) begin
               rd_in = {22'd0, best_ff};
               if (best_ff != idci_pkg::NoLine) begin
                  pnd_in[best_ff[L-1:0]] = 1'b0;
                  act_in[best_ff[L-1:0]] = 1'b1;
               end
            end
         end else if (off == idci_pkg::OffEoir) begin
            if (wr && cur_ff.write_data[9:0] < 10'(N))
               act_in[cur_ff.write_data[L-1:0]] = 1'b0;
         end
      end else if (wr || rdc) begin
         if (off == idci_pkg::OffCtlr) begin
            if (wr) dist_on_in = cur_ff.write_data[0];
            else rd_in = {31'd0, dist_on_ff};
         end else if (off == idci_pkg::OffTyper) begin
            if (rdc) rd_in = {31'd0, groups_minus_one};
         end else if (off < idci_pkg::OffSetPnd) begin
            rel = off - ((off < idci_pkg::OffClrEn) ? idci_pkg::OffSetEn : idci_pkg::OffClrEn);
            w = int'(rel[11:2]);
            for (int k = 0; k < 32; k++)
               if (w*32 + k < N) begin
                  if (wr && cur_ff.write_data[k])
                     en_in[w*32+k] = (off < idci_pkg::OffClrEn);
                  if (rdc) rd_in[k] = en_ff[w*32+k];
               end
         end else if (off < idci_pkg::OffPrio) begin
            rel = off - ((off < idci_pkg::OffClrPnd) ? idci_pkg::OffSetPnd : idci_pkg::OffClrPnd);
            w = int'(rel[11:2]);
            for (int k = 0; k < 32; k++)
               if (w*32 + k < N) begin
                  if (wr && cur_ff.write_data[k])
                     pnd_in[w*32+k] = (off < idci_pkg::OffClrPnd);
                  if (rdc) rd_in[k] = pend_now[w*32+k];
               end
         end else if (off < idci_pkg::OffCfg) begin
            rel = off - ((off < idci_pkg::OffTgt) ? idci_pkg::OffPrio : idci_pkg::OffTgt);
            w = int'(rel[11:2]);
            for (int k = 0; k < 4; k++)
               if (w*4 + k < N) begin
                  if (off < idci_pkg::OffTgt) begin
                     if (wr) prio_in[w][8*k +: 8] = cur_ff.write_data[8*k +: 8];
                     else rd_in[8*k +: 8] = prio_ff[w][8*k +: 8];
                  end else begin
                     if (wr) tgt_in[w][8*k +: 8] = cur_ff.write_data[8*k +: 8];
                     else rd_in[8*k +: 8] = tgt_ff[w][8*k +: 8];
                  end
               end
         end else if (off < idci_pkg::OffSgir) begin
            rel = off - idci_pkg::OffCfg;
            w = int'(rel[11:2]);
            for (int k = 0; k < 16; k++)
               if (w*16 + k < N) begin
                  if (wr) edge_in[w*16+k] = cur_ff.write_data[2*k+1];
                  else rd_in[2*k+1] = edge_ff[w*16+k];
               end
         end else begin
            if (wr && (((cur_ff.write_data[25:24] == 2'd0) && cur_ff.write_data[16]) ||
                       (cur_ff.write_data[25:24] == 2'd2)))
               pnd_in[cur_ff.write_data[3:0]] = 1'b1;
         end
      end
      pend_after = pnd_in | (~edge_in & high_in);
      for (int i = 0; i < N; i++)
         deliver[i] = en_in[i] && pend_after[i] && !act_in[i] &&
                      (prio_in[i/4][8*(i%4) +: 8] < pmr_in);
      irq_in = dist_on_in && cpu_on_in && (deliver != '0);
   end

   logic apply;
   assign apply = (state_ff == idci_pkg::BK_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= '0; pnd_ff <= '0; act_ff <= '0; edge_ff <= '0; high_ff <= '0;
         dist_on_ff <= 1'b0; cpu_on_ff <= 1'b0; pmr_ff <= '0;
         for (int i = 0; i < B; i++) begin
            prio_ff[i] <= '0;
            tgt_ff[i]  <= '0;
         end
         ovalid_ff <= 1'b0;
      end else begin
         if (apply) begin
            en_ff <= en_in; pnd_ff <= pnd_in; act_ff <= act_in; edge_ff <= edge_in;
            high_ff <= high_in; dist_on_ff <= dist_on_in; cpu_on_ff <= cpu_on_in;
            pmr_ff <= pmr_in;
            for (int i = 0; i < B; i++) begin
               prio_ff[i] <= prio_in[i];
               tgt_ff[i]  <= tgt_in[i];
            end
         end
         if (apply) ovalid_ff <= 1'b1;
         else if (!rsp_stall) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         odata_ff <= rd_in;
         oirq_ff  <= irq_in;
         obad_ff  <= cur_ff.bad;
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_read_data   = odata_ff;
   assign rsp_irq_request = oirq_ff;
   assign rsp_bad_offset  = obad_ff;

`ifndef SYNTHESIS
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == idci_pkg::BK_SCAN && scan_last |=> state_ff == idci_pkg::BK_DONE)
      else $error("scan did not finish");
   a_iar_best: assert property (@(posedge clock) disable iff (reset)
      apply && is_iar && best_ff != idci_pkg::NoLine |-> best_ff < 10'(N))
      else $error("acknowledge index out of range");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == idci_pkg::BK_IDLE) else $error("pop while busy");
`endif

endmodule

// File: rtl/core/interrupt_distributor_cpu_interface_top.sv
// ----------------------------------------------------------------------------
// Interrupt distributor and CPU interface, top level
// Single-CPU distributor with per-line stores and an acknowledge scanner.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one bus read, bus write or line level
// change per transfer; the rsp_ channel returns exactly one transfer for
// each, with read data, the interrupt request after the item, and a flag
// for unimplemented offsets. csr_write_enable loads the group count minus one
// that the type register reports; write it only while the block is idle.
// For each item the back end scans the 64 line priorities one per cycle,
// then applies the item in the done state. A two-entry queue sits between
// front and back, so up to two further items are taken while the back end
// works. The back end takes no new item until it has applied the last one,
// so the priority scan sets the sustained throughput.
// Reset is synchronous and clears all stores, the queue and the response.
// When the receiver stalls, the response register holds its value and the
// back end waits before applying the next item; the queue then fills and
// req_stall rises.
// ----------------------------------------------------------------------------
module interrupt_distributor_cpu_interface_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_cpu_side,
   input  logic [11:0] req_byte_offset,
   input  logic [31:0] req_write_data,
   input  logic [5:0]  req_line_number,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_request,
   output logic        rsp_bad_offset
);

   logic               groups_ff;
   logic               q_valid, q_pop;
   idci_pkg::item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff <= 1'b1;
      end else if (csr_write_enable) begin
         groups_ff <= csr_write_data;
      end
   end

   idci_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_cpu_side,
      .req_byte_offset, .req_write_data, .req_line_number, .req_line_level,
      .q_valid, .q_item, .q_pop
   );

   idci_back u_back (
      .clock, .reset, .groups_minus_one(groups_ff), .q_valid, .q_item, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_read_data, .rsp_irq_request, .rsp_bad_offset
   );

endmodule
